### rtl/pbs_pkg.sv
// package for the priority based process scheduler
// holds slot states, modes, record layout and the priority saturation helper
package pbs_pkg;

  localparam int unsigned TableSlotsDefault = 64;
  localparam int unsigned PrioMax = 100;
  localparam logic [6:0] PrioReset = 7'd60;

  localparam logic [2:0] ModeTick   = 3'd0;
  localparam logic [2:0] ModeCreate = 3'd1;
  localparam logic [2:0] ModeSetSt  = 3'd2;
  localparam logic [2:0] ModeSetPri = 3'd3;
  localparam logic [2:0] ModePick   = 3'd4;

  localparam logic [2:0] StUnused   = 3'd0;
  localparam logic [2:0] StUsed     = 3'd1;
  localparam logic [2:0] StSleeping = 3'd2;
  localparam logic [2:0] StRunnable = 3'd3;
  localparam logic [2:0] StRunning  = 3'd4;
  localparam logic [2:0] StZombie   = 3'd5;

  // one table slot as stored in memory
  typedef struct packed {
    logic [2:0]  state;
    logic [15:0] pid;
    logic [6:0]  prio;
    logic [31:0] run_ticks;
    logic [31:0] sleep_ticks;
    logic [31:0] run_count;
    logic [31:0] create_tick;
  } slot_t;

  localparam int unsigned SlotW = $bits(slot_t);

  // saturate a 7 bit priority to the legal maximum
  function automatic logic [6:0] sat_prio(input logic [6:0] v);
    sat_prio = (v > 7'(PrioMax)) ? 7'(PrioMax) : v;
  endfunction

endpackage

### rtl/pbs_ram.sv
// generic ram with one write port and one registered read port
// no dependencies
module pbs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/pbs_nice_div.sv
// restoring divider for the niceness ratio sleep*10/(sleep+run)
// no dependencies; quotient is 0..10 so four steps suffice
module pbs_nice_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] sleep_i,
  input  logic [31:0] run_i,
  output logic        done_o,
  output logic [3:0]  nice_o
);

  logic [36:0] num_q, num_d;
  logic [32:0] den_q, den_d;
  logic [3:0]  quo_q, quo_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        zero_q, zero_d;
  logic [36:0] trial;

  // shifted denominator for the current quotient bit
  always_comb begin
    trial = 37'(den_q) << (cnt_q - 3'd1);
  end

  always_comb begin
    num_d = num_q; den_d = den_q; quo_d = quo_q; cnt_d = cnt_q;
    busy_d = busy_q; zero_d = zero_q;
    if (start_i) begin
      num_d = ({5'd0, sleep_i} << 3) + ({5'd0, sleep_i} << 1);
      den_d = {1'b0, sleep_i} + {1'b0, run_i};
      zero_d = (sleep_i == 32'd0) && (run_i == 32'd0);
      quo_d = 4'd0;
      cnt_d = 3'd4;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (num_q >= trial) begin
        num_d = num_q - trial;
        quo_d = quo_q | (4'd1 << (cnt_q - 3'd1));
      end
      cnt_d = cnt_q - 3'd1;
      if (cnt_q == 3'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; den_q <= den_d; quo_q <= quo_d; zero_q <= zero_d;
  end

  assign done_o = busy_q && (cnt_q == 3'd1);
  assign nice_o = zero_q ? 4'd5 :
                  ((num_q >= trial) ? (quo_q | (4'd1 << (cnt_q - 3'd1))) : quo_q);

endmodule

### rtl/priority_based_process_scheduler.sv
// Priority based process scheduler with niceness.
// Input channel (in_valid_i / in_ready_o) carries one command per transaction:
// mode, slot, proc_id, new_state, set_prio. Output channel
// (out_valid_o / out_ready_i) returns exactly one result per command.
// Config channel (cfg_valid_i / cfg_ready_o) writes default_priority.
// The slot table lives in one synchronous ram, one slot per word.
// After reset a clearing pass writes every slot to zero, during which no command is accepted.
// Create and set state read the slot, wait for the ram, modify and write it back;
// tick walks all slots the same way; set priority walks until the first match;
// pick reads every slot, runs the nice divider on each runnable slot, then
// reads the winner back and writes it as running.
// Undefined modes and out of range slots give their result in the next cycle.
// The result sits in an output register; while the receiver stalls the block
// holds it and accepts no new command until it is taken.
// Uses pbs_pkg, pbs_ram and pbs_nice_div.
module priority_based_process_scheduler #(
  parameter int unsigned TABLE_SLOTS = pbs_pkg::TableSlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [5:0]  slot_i,
  input  logic [15:0] proc_id_i,
  input  logic [2:0]  new_state_i,
  input  logic [6:0]  set_prio_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        picked_valid_o,
  output logic [5:0]  picked_slot_o,
  output logic [6:0]  picked_dyn_priority_o,
  output logic        pid_found_o,
  output logic [6:0]  old_priority_o,
  output logic        reschedule_o
);

  localparam int unsigned AW = $clog2(TABLE_SLOTS);
  localparam int unsigned CW = AW + 1;

  localparam logic [3:0] SClear = 4'd0;
  localparam logic [3:0] SIdle  = 4'd1;
  localparam logic [3:0] SRd    = 4'd2;
  localparam logic [3:0] SWait  = 4'd3;
  localparam logic [3:0] SMod   = 4'd4;
  localparam logic [3:0] SDiv   = 4'd5;
  localparam logic [3:0] SWin   = 4'd6;
  localparam logic [3:0] SWinW  = 4'd7;
  localparam logic [3:0] SWinM  = 4'd8;
  localparam logic [3:0] SOut   = 4'd9;

  logic [3:0]  st_q, st_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [2:0]  mode_q;
  logic [15:0] pid_q;
  logic [2:0]  nst_q;
  logic [6:0]  npr_q;
  logic [6:0]  defp_q;
  logic [31:0] tick_q, tick_d;

  logic        have_q, have_d;
  logic [AW-1:0] best_q, best_d;
  logic [6:0]  bestd_q, bestd_d;
  logic [31:0] bestrc_q, bestrc_d;
  logic [31:0] bestct_q, bestct_d;

  logic        r_pv_q, r_pv_d, r_pf_q, r_pf_d, r_rs_q, r_rs_d;
  logic [5:0]  r_ps_q, r_ps_d;
  logic [6:0]  r_pd_q, r_pd_d, r_op_q, r_op_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  pbs_pkg::slot_t wdata, rdata, cur;
  logic [pbs_pkg::SlotW-1:0] rdata_raw;

  logic       div_start, div_done;
  logic [3:0] div_nice;
  logic [7:0] dyn_raw;
  logic [6:0] dyn;
  logic       better;
  logic       last;

  assign cur = rdata;
  assign rdata = pbs_pkg::slot_t'(rdata_raw);

  pbs_ram #(.Width(pbs_pkg::SlotW), .Depth(TABLE_SLOTS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );

  pbs_nice_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .sleep_i(cur.sleep_ticks),
    .run_i  (cur.run_ticks),
    .done_o (div_done),
    .nice_o (div_nice)
  );

  // dynamic priority: prio - nice + 5 clamped to 0..100
  always_comb begin
    dyn_raw = {1'b0, cur.prio} + 8'd5 - {4'd0, div_nice};
    if (dyn_raw[7]) dyn = 7'd0;
    else if (dyn_raw > 8'(pbs_pkg::PrioMax)) dyn = 7'(pbs_pkg::PrioMax);
    else dyn = dyn_raw[6:0];
    better = !have_q || dyn < bestd_q ||
             (dyn == bestd_q && cur.run_count < bestrc_q) ||
             (dyn == bestd_q && cur.run_count == bestrc_q && cur.create_tick < bestct_q);
  end

  assign last = (idx_q == CW'(TABLE_SLOTS - 1));
  assign in_ready_o  = (st_q == SIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (st_q == SOut);

  // sequencer: clear after reset; per slot read, wait for the registered ram read, modify, write back
  always_comb begin
    st_d = st_q; idx_d = idx_q; tick_d = tick_q;
    have_d = have_q; best_d = best_q; bestd_d = bestd_q;
    bestrc_d = bestrc_q; bestct_d = bestct_q;
    r_pv_d = r_pv_q; r_ps_d = r_ps_q; r_pd_d = r_pd_q;
    r_pf_d = r_pf_q; r_op_d = r_op_q; r_rs_d = r_rs_q;
    we = 1'b0; waddr = idx_q[AW-1:0]; wdata = cur;
    raddr = idx_q[AW-1:0]; div_start = 1'b0;
    case (st_q)
      SClear: begin
        we = 1'b1; wdata = '0;
        idx_d = idx_q + CW'(1);
        if (last) st_d = SIdle;
      end
      SIdle: begin
        if (in_valid_i) begin
          r_pv_d = 1'b0; r_ps_d = '0; r_pd_d = '0;
          r_pf_d = 1'b0; r_op_d = '0; r_rs_d = 1'b0;
          have_d = 1'b0;
          case (mode_i)
            pbs_pkg::ModeTick: begin
              tick_d = tick_q + 32'd1; idx_d = '0; st_d = SRd;
            end
            pbs_pkg::ModeCreate, pbs_pkg::ModeSetSt: begin
              if ({26'd0, slot_i} < 32'(TABLE_SLOTS)) begin
                idx_d = CW'(slot_i); st_d = SRd;
              end else st_d = SOut;
            end
            pbs_pkg::ModeSetPri, pbs_pkg::ModePick: begin
              idx_d = '0; st_d = SRd;
            end
            default: st_d = SOut;
          endcase
        end
      end
      SRd: st_d = SWait;
      SWait: st_d = SMod;
      SMod: begin
        st_d = SOut;
        case (mode_q)
          pbs_pkg::ModeTick: begin
            we = 1'b1;
            if (cur.state == pbs_pkg::StRunning)
              wdata.run_ticks = cur.run_ticks + 32'd1;
            else if (cur.state == pbs_pkg::StSleeping)
              wdata.sleep_ticks = cur.sleep_ticks + 32'd1;
            if (!last) begin idx_d = idx_q + CW'(1); st_d = SRd; end
          end
          pbs_pkg::ModeCreate: begin
            we = 1'b1;
            wdata.state = pbs_pkg::StUsed;
            wdata.pid = pid_q;
            wdata.prio = pbs_pkg::sat_prio(defp_q);
            wdata.run_ticks = '0; wdata.sleep_ticks = '0;
            wdata.run_count = '0; wdata.create_tick = tick_q;
          end
          pbs_pkg::ModeSetSt: begin
            if (nst_q <= pbs_pkg::StZombie) begin
              we = 1'b1; wdata.state = nst_q;
            end
          end
          pbs_pkg::ModeSetPri: begin
            if (cur.state != pbs_pkg::StUnused && cur.pid == pid_q) begin
              we = 1'b1;
              wdata.prio = pbs_pkg::sat_prio(npr_q);
              wdata.run_ticks = '0; wdata.sleep_ticks = '0;
              r_pf_d = 1'b1; r_op_d = cur.prio;
              r_rs_d = pbs_pkg::sat_prio(npr_q) < cur.prio;
            end else if (!last) begin
              idx_d = idx_q + CW'(1); st_d = SRd;
            end
          end
          pbs_pkg::ModePick: begin
            if (cur.state == pbs_pkg::StRunnable) begin
              div_start = 1'b1; st_d = SDiv;
            end else if (!last) begin
              idx_d = idx_q + CW'(1); st_d = SRd;
            end else if (have_q) st_d = SWin;
          end
          default: st_d = SOut;
        endcase
      end
      SDiv: begin
        if (div_done) begin
          if (better) begin
            have_d = 1'b1; best_d = idx_q[AW-1:0]; bestd_d = dyn;
            bestrc_d = cur.run_count; bestct_d = cur.create_tick;
          end
          if (!last) begin idx_d = idx_q + CW'(1); st_d = SRd; end
          else st_d = SWin;
        end
      end
      SWin: begin raddr = best_q; st_d = SWinW; end
      SWinW: begin raddr = best_q; st_d = SWinM; end
      SWinM: begin
        we = 1'b1; waddr = best_q;
        wdata.state = pbs_pkg::StRunning;
        wdata.run_ticks = '0; wdata.sleep_ticks = '0;
        wdata.run_count = cur.run_count + 32'd1;
        r_pv_d = 1'b1; r_ps_d = 6'(best_q); r_pd_d = bestd_q;
        st_d = SOut;
      end
      SOut: if (out_ready_i) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= SClear;
      idx_q  <= '0;
      tick_q <= '0;
      defp_q <= pbs_pkg::PrioReset;
      have_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      idx_q  <= idx_d;
      tick_q <= tick_d;
      have_q <= have_d;
      if (cfg_valid_i) defp_q <= cfg_data_i;
    end
  end

  // command and result payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q <= mode_i; pid_q <= proc_id_i;
      nst_q <= new_state_i; npr_q <= set_prio_i;
    end
    best_q <= best_d; bestd_q <= bestd_d; bestrc_q <= bestrc_d; bestct_q <= bestct_d;
    r_pv_q <= r_pv_d; r_ps_q <= r_ps_d; r_pd_q <= r_pd_d;
    r_pf_q <= r_pf_d; r_op_q <= r_op_d; r_rs_q <= r_rs_d;
  end

  assign picked_valid_o        = r_pv_q;
  assign picked_slot_o         = r_ps_q;
  assign picked_dyn_priority_o = r_pd_q;
  assign pid_found_o           = r_pf_q;
  assign old_priority_o        = r_op_q;
  assign reschedule_o          = r_rs_q;

endmodule

### rtl/pbs_checker.sv
// port level checks for the process scheduler
// bound to priority_based_process_scheduler; no other dependencies
module pbs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       picked_valid_o,
  input logic       pid_found_o,
  input logic [6:0] picked_dyn_priority_o,
  input logic       reschedule_o
);

  // the input is closed in the cycle after a command is taken
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("busy input");

  // no command is accepted while a result is pending
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("overlap");

  // pick and set priority results are exclusive
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(picked_valid_o && pid_found_o)) else $error("both");

  // dynamic priority stays in range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> picked_dyn_priority_o <= 7'd100) else $error("range");

  // reschedule only with a found pid
  a_resched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reschedule_o) |-> pid_found_o) else $error("resched");

endmodule

bind priority_based_process_scheduler pbs_checker u_pbs_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
  .picked_valid_o(picked_valid_o), .pid_found_o(pid_found_o),
  .picked_dyn_priority_o(picked_dyn_priority_o), .reschedule_o(reschedule_o)
);

### tb/sv/tb_top.sv
// testbench for priority_based_process_scheduler: drives commands and config writes
// and checks every result against an in-bench model of the slot table
// depends on pbs_pkg and the scheduler rtl
`timescale 1ns / 100ps

module tb_top;

  localparam int Slots = 64;
  localparam int IdleLimit = 200000;

  typedef struct packed {
    logic       picked_valid;
    logic [5:0] picked_slot;
    logic [6:0] picked_dyn_priority;
    logic       pid_found;
    logic [6:0] old_priority;
    logic       reschedule;
  } sched_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  mode_i = '0;
  logic [5:0]  slot_i = '0;
  logic [15:0] proc_id_i = '0;
  logic [2:0]  new_state_i = '0;
  logic [6:0]  set_prio_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        picked_valid_o;
  logic [5:0]  picked_slot_o;
  logic [6:0]  picked_dyn_priority_o;
  logic        pid_found_o;
  logic [6:0]  old_priority_o;
  logic        reschedule_o;

  // model of the process table
  logic [2:0]  m_state[Slots];
  logic [15:0] m_pid[Slots];
  logic [6:0]  m_prio[Slots];
  logic [31:0] m_run[Slots];
  logic [31:0] m_sleep[Slots];
  logic [31:0] m_runs[Slots];
  logic [31:0] m_ctick[Slots];
  logic [31:0] m_ticks;
  logic [6:0]  m_def_prio;

  sched_res_t pending_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;
  bit hold_off = 1'b0;
  bit stall_en = 1'b1;

  priority_based_process_scheduler u_top (.*);

  always #10 clk_i = ~clk_i;

  // dynamic priority of one slot
  function automatic int dyn_prio(int i);
    logic [32:0] tot;
    logic [36:0] num;
    int nice;
    int d;
    tot = {1'b0, m_sleep[i]} + {1'b0, m_run[i]};
    num = {5'b0, m_sleep[i]} * 37'd10;
    nice = (tot == 0) ? 5 : int'(num / {4'b0, tot});
    d = int'(m_prio[i]) - nice + 5;
    if (d < 0) d = 0;
    if (d > 100) d = 100;
    return d;
  endfunction

  // update the table for one command and return the expected result
  function automatic sched_res_t schedule_cmd(logic [2:0] md, logic [5:0] sl,
                                              logic [15:0] pid, logic [2:0] ns,
                                              logic [6:0] np);
    sched_res_t r;
    int best;
    int bestd;
    int d;
    logic [6:0] newp;
    r = '0;
    best = -1;
    bestd = 0;
    newp = (np > 7'd100) ? 7'd100 : np;
    case (md)
      pbs_pkg::ModeTick: begin
        m_ticks++;
        for (int i = 0; i < Slots; i++) begin
          if (m_state[i] == pbs_pkg::StRunning) m_run[i]++;
          else if (m_state[i] == pbs_pkg::StSleeping) m_sleep[i]++;
        end
      end
      pbs_pkg::ModeCreate: begin
        m_state[sl] = pbs_pkg::StUsed;
        m_pid[sl] = pid;
        m_prio[sl] = (m_def_prio > 7'd100) ? 7'd100 : m_def_prio;
        m_run[sl] = '0;
        m_sleep[sl] = '0;
        m_runs[sl] = '0;
        m_ctick[sl] = m_ticks;
      end
      pbs_pkg::ModeSetSt: begin
        if (ns <= pbs_pkg::StZombie) m_state[sl] = ns;
      end
      pbs_pkg::ModeSetPri: begin
        for (int i = 0; i < Slots; i++) begin
          if (m_state[i] != pbs_pkg::StUnused && m_pid[i] == pid) begin
            r.pid_found = 1'b1;
            r.old_priority = m_prio[i];
            r.reschedule = newp < m_prio[i];
            m_prio[i] = newp;
            m_run[i] = '0;
            m_sleep[i] = '0;
            break;
          end
        end
      end
      pbs_pkg::ModePick: begin
        for (int i = 0; i < Slots; i++) begin
          if (m_state[i] != pbs_pkg::StRunnable) continue;
          d = dyn_prio(i);
          if (best < 0 || d < bestd ||
              (d == bestd && m_runs[i] < m_runs[best]) ||
              (d == bestd && m_runs[i] == m_runs[best] && m_ctick[i] < m_ctick[best])) begin
            best = i;
            bestd = d;
          end
        end
        if (best >= 0) begin
          m_state[best] = pbs_pkg::StRunning;
          m_run[best] = '0;
          m_sleep[best] = '0;
          m_runs[best]++;
          r.picked_valid = 1'b1;
          r.picked_slot = best[5:0];
          r.picked_dyn_priority = bestd[6:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  // send one command transaction
  task automatic send_cmd(logic [2:0] md, logic [5:0] sl, logic [15:0] pid,
                          logic [2:0] ns, logic [6:0] np);
    int g;
    g = stall_en ? gap_len() : 0;
    repeat (g) @(posedge clk_i);
    in_valid_i <= 1'b1;
    mode_i <= md;
    slot_i <= sl;
    proc_id_i <= pid;
    new_state_i <= ns;
    set_prio_i <= np;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(schedule_cmd(md, sl, pid, ns, np));
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drain();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (800) @(posedge clk_i);
  endtask

  // write default priority while idle
  task automatic write_default(logic [6:0] v);
    wait_drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    m_def_prio = v;
  endtask

  // directed: field extremes, every mode, odd cases
  task automatic test_directed();
    send_cmd(pbs_pkg::ModePick, '0, '0, '0, '0);
    send_cmd(pbs_pkg::ModeSetPri, '0, 16'h0000, '0, 7'd10);
    send_cmd(pbs_pkg::ModeCreate, 6'd0, 16'h0000, '0, '0);
    send_cmd(pbs_pkg::ModeCreate, 6'd63, 16'hffff, '0, '0);
    send_cmd(pbs_pkg::ModeCreate, 6'd5, 16'hffff, '0, '0);
    send_cmd(pbs_pkg::ModeSetSt, 6'd0, '0, pbs_pkg::StRunnable, '0);
    send_cmd(pbs_pkg::ModeSetSt, 6'd63, '0, pbs_pkg::StRunnable, '0);
    send_cmd(pbs_pkg::ModeSetSt, 6'd5, '0, pbs_pkg::StSleeping, '0);
    send_cmd(pbs_pkg::ModeSetSt, 6'd5, '0, 3'd7, '0);
    send_cmd(pbs_pkg::ModeSetSt, 6'd5, '0, 3'd6, '0);
    send_cmd(pbs_pkg::ModePick, '0, '0, '0, '0);
    send_cmd(pbs_pkg::ModeTick, '0, '0, '0, '0);
    send_cmd(pbs_pkg::ModeTick, '0, '0, '0, '0);
    send_cmd(pbs_pkg::ModeSetPri, '0, 16'hffff, '0, 7'd127);
    send_cmd(pbs_pkg::ModeSetPri, '0, 16'hffff, '0, 7'd0);
    send_cmd(pbs_pkg::ModeSetSt, 6'd5, '0, pbs_pkg::StRunnable, '0);
    send_cmd(pbs_pkg::ModePick, '0, '0, '0, '0);
    send_cmd(pbs_pkg::ModePick, '0, '0, '0, '0);
    send_cmd(3'd5, 6'd1, 16'h1, '0, '0);
    send_cmd(3'd7, 6'd2, 16'h2, 3'd7, 7'd127);
    send_cmd(pbs_pkg::ModeSetSt, 6'd0, '0, pbs_pkg::StZombie, '0);
    send_cmd(pbs_pkg::ModeSetSt, 6'd63, '0, pbs_pkg::StUnused, '0);
  endtask

  // random commands, mostly on a small pid set so set priority hits
  task automatic test_random(int n);
    logic [2:0] md;
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 30) md = pbs_pkg::ModeTick;
      else if (r < 45) md = pbs_pkg::ModeCreate;
      else if (r < 70) md = pbs_pkg::ModeSetSt;
      else if (r < 80) md = pbs_pkg::ModeSetPri;
      else if (r < 97) md = pbs_pkg::ModePick;
      else md = 3'($urandom_range(5, 7));
      send_cmd(md, ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 11)),
               ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7)),
               ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(2, 4)),
               7'($urandom));
    end
  endtask

  // receiver holds off long while commands keep coming
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      test_random(20);
    join
  endtask

  // sender pauses until every result is back
  task automatic test_drain_pause();
    test_random(30);
    wait_drain();
    stall_en = 1'b0;
    test_random(60);
    stall_en = 1'b1;
  endtask

  // receiver ready with random stalls
  always @(posedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(0, 3) != 0);
  end

  // result checker
  always @(posedge clk_i) begin
    sched_res_t got;
    sched_res_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {picked_valid_o, picked_slot_o, picked_dyn_priority_o,
             pid_found_o, old_priority_o, reschedule_o};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %h", got);
      end else begin
        exp_res = pending_results.pop_front();
        if (got !== exp_res) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp pv=%0d ps=%0d pd=%0d pf=%0d op=%0d rs=%0d",
                     exp_res.picked_valid, exp_res.picked_slot, exp_res.picked_dyn_priority,
                     exp_res.pid_found, exp_res.old_priority, exp_res.reschedule);
            $display("          got pv=%0d ps=%0d pd=%0d pf=%0d op=%0d rs=%0d",
                     got.picked_valid, got.picked_slot, got.picked_dyn_priority,
                     got.pid_found, got.old_priority, got.reschedule);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IdleLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("FAIL priority_based_process_scheduler");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < Slots; i++) begin
      m_state[i] = pbs_pkg::StUnused;
      m_pid[i] = '0;
      m_prio[i] = '0;
      m_run[i] = '0;
      m_sleep[i] = '0;
      m_runs[i] = '0;
      m_ctick[i] = '0;
    end
    m_ticks = '0;
    m_def_prio = pbs_pkg::PrioReset;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    write_default(7'd0);
    test_random(150);
    write_default(7'd127);
    test_random(150);
    write_default(7'd100);
    test_backpressure();
    test_drain_pause();
    write_default(7'd35);
    test_random(450);
    write_default(7'd60);
    test_random(350);
    wait_drain();
    if (mismatches == 0) $display("PASS priority_based_process_scheduler");
    else $display("FAIL priority_based_process_scheduler");
    $finish;
  end

endmodule

### priority_based_process_scheduler.f
rtl/pbs_pkg.sv
rtl/pbs_ram.sv
rtl/pbs_nice_div.sv
rtl/priority_based_process_scheduler.sv
rtl/pbs_checker.sv
tb/sv/tb_top.sv
